FILE: rtl/sha_pkg.sv
package sha_pkg;

	typedef struct packed {
		logic        en;
		logic [3:0]  addr;
		logic [31:0] data;
	} wmem_wr_t;

	typedef struct packed {
		logic        en;
		logic [2:0]  addr;
		logic [31:0] data;
	} hmem_wr_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [63:0] BLOCK_BITS = 64'd512;

	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] v;
		case (i)
			3'd0: v = 32'h6a09e667;
			3'd1: v = 32'hbb67ae85;
			3'd2: v = 32'h3c6ef372;
			3'd3: v = 32'ha54ff53a;
			3'd4: v = 32'h510e527f;
			3'd5: v = 32'h9b05688c;
			3'd6: v = 32'h1f83d9ab;
			default: v = 32'h5be0cd19;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] v;
		case (i)
			6'd0: v = 32'h428a2f98; 6'd1: v = 32'h71374491; 6'd2: v = 32'hb5c0fbcf;
			6'd3: v = 32'he9b5dba5; 6'd4: v = 32'h3956c25b; 6'd5: v = 32'h59f111f1;
			6'd6: v = 32'h923f82a4; 6'd7: v = 32'hab1c5ed5; 6'd8: v = 32'hd807aa98;
			6'd9: v = 32'h12835b01; 6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
			6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe; 6'd14: v = 32'h9bdc06a7;
			6'd15: v = 32'hc19bf174; 6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
			6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc; 6'd20: v = 32'h2de92c6f;
			6'd21: v = 32'h4a7484aa; 6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
			6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d; 6'd26: v = 32'hb00327c8;
			6'd27: v = 32'hbf597fc7; 6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
			6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967; 6'd32: v = 32'h27b70a85;
			6'd33: v = 32'h2e1b2138; 6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
			6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb; 6'd38: v = 32'h81c2c92e;
			6'd39: v = 32'h92722c85; 6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
			6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3; 6'd44: v = 32'hd192e819;
			6'd45: v = 32'hd6990624; 6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
			6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08; 6'd50: v = 32'h2748774c;
			6'd51: v = 32'h34b0bcb5; 6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
			6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3; 6'd56: v = 32'h748f82ee;
			6'd57: v = 32'h78a5636f; 6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
			6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb; 6'd62: v = 32'hbef9a3f7;
			default: v = 32'hc67178f2;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/sha_blkmem.sv
module sha_blkmem import sha_pkg::*; (
	input  logic        clk,
	input  wmem_wr_t    wr,
	input  logic [3:0]  rd_addr,
	output logic [31:0] rd_data
);

	logic [31:0] mem [16];
	logic [31:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/sha_hashmem.sv
module sha_hashmem import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  hmem_wr_t    wr,
	input  logic        clr,
	input  logic [2:0]  rd_addr,
	output logic [31:0] rd_data
);

	logic [31:0] mem [8];
	logic [31:0] mem_rd_q;
	logic [7:0]  vld_q;
	logic        vld_rd_q;
	logic [2:0]  addr_rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		mem_rd_q <= mem[rd_addr];
		addr_rd_q <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			vld_rd_q <= vld_q[rd_addr];
			if (clr) begin
				vld_q <= '0;
			end else if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
		end
	end

	assign rd_data = vld_rd_q ? mem_rd_q : init_h(addr_rd_q);

endmodule

FILE: rtl/sha256_stream_hasher_top.sv
// Absorb takes input bytes while idle; every 64th byte starts a compression, during which
// input is stalled (hash load, 64 rounds at one per cycle, write-back).
// Finish pads with the 0x80 byte, zeros and the bit length, compresses one or two blocks, then offers
// eight digest items, one per cycle while the sink is ready.
// The asynchronous reset clears control state and marks the hash memory as holding
// the initial hash values; the block buffer is left undefined.
module sha256_stream_hasher_top import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [31:0] digest_word, [34:32] word_index, zero fill
	output logic        m_axis_tlast
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PAD   = 3'd1;
	localparam logic [2:0] S_HLOAD = 3'd2;
	localparam logic [2:0] S_ROUND = 3'd3;
	localparam logic [2:0] S_HUPD  = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0]  state_q;
	logic [6:0]  cnt_q;
	logic [5:0]  byte_cnt_q;
	logic [23:0] asm_q;
	logic [63:0] tot_q;
	logic [63:0] len_q;
	logic [3:0]  pad_idx_q;
	logic        first_q;
	logic        lenblk_q;
	logic        fin_q;
	logic [2:0]  out_idx_q;
	logic [31:0] wk_q [8];
	logic [31:0] sch_q [16];
	logic [31:0] dig_q [8];

	wmem_wr_t    wwr;
	hmem_wr_t    hwr;
	logic        hclr;
	logic [3:0]  w_rd_addr;
	logic [31:0] w_rd_data;
	logic [2:0]  h_rd_addr;
	logic [31:0] h_rd_data;
	logic [31:0] pad_word;
	logic [31:0] w_new;
	logic [31:0] w_cur;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] hsum;
	logic        in_acc;
	logic        out_acc;
	logic        last_upd;

	function automatic logic [31:0] ror(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	sha_blkmem u_blkmem (
		.clk     (clk),
		.wr      (wwr),
		.rd_addr (w_rd_addr),
		.rd_data (w_rd_data)
	);

	sha_hashmem u_hashmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (hwr),
		.clr     (hclr),
		.rd_addr (h_rd_addr),
		.rd_data (h_rd_data)
	);

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (state_q == S_OUT);
	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata = {5'b0, out_idx_q, dig_q[0]};
	assign m_axis_tlast = (out_idx_q == 3'd7);
	assign last_upd = (state_q == S_HUPD) && (cnt_q == 7'd8);

	always_comb begin
		case (byte_cnt_q[1:0])
			2'd0: pad_word = {PAD_BYTE, 24'h0};
			2'd1: pad_word = {asm_q[7:0], PAD_BYTE, 16'h0};
			2'd2: pad_word = {asm_q[15:0], PAD_BYTE, 8'h0};
			default: pad_word = {asm_q[23:0], PAD_BYTE};
		endcase
	end

	assign w_new = (ror(sch_q[14], 17) ^ ror(sch_q[14], 19) ^ (sch_q[14] >> 10)) + sch_q[9]
		+ (ror(sch_q[1], 7) ^ ror(sch_q[1], 18) ^ (sch_q[1] >> 3)) + sch_q[0];
	assign w_cur = (cnt_q < 7'd16) ? w_rd_data : w_new;
	assign t1 = wk_q[7] + (ror(wk_q[4], 6) ^ ror(wk_q[4], 11) ^ ror(wk_q[4], 25))
		+ ((wk_q[4] & wk_q[5]) ^ (~wk_q[4] & wk_q[6])) + round_k(cnt_q[5:0]) + w_cur;
	assign t2 = (ror(wk_q[0], 2) ^ ror(wk_q[0], 13) ^ ror(wk_q[0], 22))
		+ ((wk_q[0] & wk_q[1]) ^ (wk_q[0] & wk_q[2]) ^ (wk_q[1] & wk_q[2]));
	assign hsum = h_rd_data + wk_q[0];

	always_comb begin
		wwr = '0;
		hwr = '0;
		hclr = 1'b0;
		w_rd_addr = 4'd0;
		h_rd_addr = cnt_q[2:0];
		case (state_q)
			S_IDLE: begin
				if (in_acc && !s_axis_tuser && byte_cnt_q[1:0] == 2'd3) begin
					wwr.en = 1'b1;
					wwr.addr = byte_cnt_q[5:2];
					wwr.data = {asm_q, s_axis_tdata};
				end
			end
			S_PAD: begin
				wwr.en = 1'b1;
				wwr.addr = pad_idx_q;
				if (first_q) begin
					wwr.data = pad_word;
				end else if (lenblk_q && pad_idx_q == 4'd14) begin
					wwr.data = len_q[63:32];
				end else if (lenblk_q && pad_idx_q == 4'd15) begin
					wwr.data = len_q[31:0];
				end else begin
					wwr.data = 32'h0;
				end
			end
			S_ROUND: begin
				w_rd_addr = cnt_q[3:0] + 4'd1;
			end
			S_HUPD: begin
				if (cnt_q != 7'd0 && !(fin_q && lenblk_q)) begin
					hwr.en = 1'b1;
					hwr.addr = cnt_q[2:0] - 3'd1;
					hwr.data = hsum;
				end
				hclr = last_upd && fin_q && lenblk_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc && !s_axis_tuser) begin
					asm_q <= {asm_q[15:0], s_axis_tdata};
				end
				if (in_acc && s_axis_tuser) begin
					len_q <= tot_q + {55'd0, byte_cnt_q, 3'd0};
				end
			end
			S_HLOAD: begin
				if (cnt_q != 7'd0) begin
					for (int i = 0; i < 7; i++) begin
						wk_q[i] <= wk_q[i + 1];
					end
					wk_q[7] <= h_rd_data;
				end
			end
			S_ROUND: begin
				for (int i = 0; i < 15; i++) begin
					sch_q[i] <= sch_q[i + 1];
				end
				sch_q[15] <= w_cur;
				wk_q[7] <= wk_q[6];
				wk_q[6] <= wk_q[5];
				wk_q[5] <= wk_q[4];
				wk_q[4] <= wk_q[3] + t1;
				wk_q[3] <= wk_q[2];
				wk_q[2] <= wk_q[1];
				wk_q[1] <= wk_q[0];
				wk_q[0] <= t1 + t2;
			end
			S_HUPD: begin
				if (cnt_q != 7'd0) begin
					for (int i = 0; i < 7; i++) begin
						wk_q[i] <= wk_q[i + 1];
						dig_q[i] <= dig_q[i + 1];
					end
					dig_q[7] <= hsum;
				end
			end
			S_OUT: begin
				if (out_acc) begin
					for (int i = 0; i < 7; i++) begin
						dig_q[i] <= dig_q[i + 1];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			byte_cnt_q <= '0;
			tot_q <= '0;
			pad_idx_q <= '0;
			first_q <= 1'b0;
			lenblk_q <= 1'b0;
			fin_q <= 1'b0;
			out_idx_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc && !s_axis_tuser) begin
						byte_cnt_q <= byte_cnt_q + 6'd1;
						if (byte_cnt_q == 6'd63) begin
							state_q <= S_HLOAD;
							cnt_q <= '0;
						end
					end else if (in_acc) begin
						fin_q <= 1'b1;
						first_q <= 1'b1;
						pad_idx_q <= byte_cnt_q[5:2];
						lenblk_q <= (byte_cnt_q < LEN_POS);
						state_q <= S_PAD;
					end
				end
				S_PAD: begin
					first_q <= 1'b0;
					pad_idx_q <= pad_idx_q + 4'd1;
					if (pad_idx_q == 4'd15) begin
						state_q <= S_HLOAD;
						cnt_q <= '0;
					end
				end
				S_HLOAD: begin
					if (cnt_q == 7'd8) begin
						state_q <= S_ROUND;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				S_ROUND: begin
					if (cnt_q == 7'd63) begin
						state_q <= S_HUPD;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				S_HUPD: begin
					cnt_q <= cnt_q + 7'd1;
					if (last_upd) begin
						cnt_q <= '0;
						if (fin_q && lenblk_q) begin
							state_q <= S_OUT;
							out_idx_q <= '0;
							byte_cnt_q <= '0;
							tot_q <= '0;
							fin_q <= 1'b0;
						end else if (fin_q) begin
							state_q <= S_PAD;
							lenblk_q <= 1'b1;
							pad_idx_q <= '0;
						end else begin
							state_q <= S_IDLE;
							tot_q <= tot_q + BLOCK_BITS;
						end
					end
				end
				S_OUT: begin
					if (out_acc) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == 3'd7) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input accepted while digest items pending");

	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND) |-> (cnt_q < 7'd64))
		else $error("round counter out of range");

	a_final_out: assert property (@(posedge clk) disable iff (!arst_n)
		(last_upd && fin_q && lenblk_q) |=> (state_q == S_OUT && out_idx_q == 3'd0))
		else $error("final compression did not lead to digest output");

endmodule
